>>> hw/rtl/vibg_pkg.sv
package vibg_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W = (FRACTION_BITS < 16) ? FRACTION_BITS : 16;

  localparam int SAMPLE_W = 16;
  localparam int ENV_W = 15;
  localparam int COEF_W = 16;
  localparam int Y_W = 20;
  localparam int Z_W = 34;
  localparam int ACC_W = 37;
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 17;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  localparam int IN_TDATA_W = 64;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [ENV_W-1:0] ENV_FULL = {ENV_W{1'b1}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_FILT = 3'd5,
    REG_GAIN = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic                     filter_on;
    logic signed [COEF_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic [ENV_W-1:0]           env;
  } item_t;

  typedef struct packed {
    logic state_clipped;
    logic filter_clipped;
    logic output_clipped;
  } flags_t;

endpackage

>>> hw/rtl/vibg_front.sv
module vibg_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [vibg_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               push_valid,
  input  logic                               push_ready,
  output vibg_pkg::item_t                    push_item
);
  import vibg_pkg::*;

  localparam int IP_W = SAMPLE_W + 2 + FRAC_W;

  logic                        busy;
  logic signed [SAMPLE_W-1:0]  s0;
  logic signed [SAMPLE_W:0]    diff;
  logic [FRAC_W-1:0]           frac;
  logic [ENV_W-1:0]            env;
  logic                        accept;
  logic                        push;
  logic signed [IP_W-1:0]      ip_prod;
  logic signed [IP_W-1:0]      ip_shift;
  logic signed [SAMPLE_W:0]    x_sum;
  logic signed [SAMPLE_W-1:0]  in_near;
  logic signed [SAMPLE_W-1:0]  in_next;

  assign in_near = s_tdata[SAMPLE_W-1:0];
  assign in_next = s_tdata[2*SAMPLE_W-1:SAMPLE_W];

  assign push = busy && push_ready;
  assign s_tready = !busy || push_ready;
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (push) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0 <= in_near;
      diff <= {in_next[SAMPLE_W-1], in_next} - {in_near[SAMPLE_W-1], in_near};
      frac <= s_tdata[2*SAMPLE_W +: FRAC_W];
      env <= s_tdata[3*SAMPLE_W +: ENV_W];
    end
  end

  always_comb begin
    ip_prod = IP_W'(diff) * IP_W'($signed({1'b0, frac}));
    ip_shift = ip_prod >>> FRACTION_BITS;
    x_sum = {s0[SAMPLE_W-1], s0} + ip_shift[SAMPLE_W:0];
  end

  assign push_valid = busy;
  assign push_item.x = x_sum[SAMPLE_W-1:0];
  assign push_item.env = env;

endmodule

>>> hw/rtl/vibg_queue.sv
module vibg_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  vibg_pkg::item_t  push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output vibg_pkg::item_t  pop_item
);
  import vibg_pkg::*;

  item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;
  logic               pop;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign pop_valid = (count != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count exceeds depth");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule

>>> hw/rtl/vibg_back.sv
module vibg_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  vibg_pkg::cfg_t                       cfg,
  input  logic                                 q_valid,
  output logic                                 q_ready,
  input  vibg_pkg::item_t                      q_item,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [vibg_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic [vibg_pkg::OUT_TUSER_W-1:0]     m_tuser
);
  import vibg_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MB1  = 8'b0000_0010,
    S_MA1  = 8'b0000_0100,
    S_MB2  = 8'b0000_1000,
    S_MA2  = 8'b0001_0000,
    S_MG   = 8'b0010_0000,
    S_ME   = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  localparam int YS_W = Z_W + 1;
  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};
  localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};
  localparam logic signed [OUT_TDATA_W-1:0] O_MAX = {1'b0, {(OUT_TDATA_W-1){1'b1}}};
  localparam logic signed [OUT_TDATA_W-1:0] O_MIN = {1'b1, {(OUT_TDATA_W-1){1'b0}}};

  state_t                      state;
  state_t                      state_next;
  logic signed [SAMPLE_W-1:0]  x;
  logic [ENV_W-1:0]            env;
  logic signed [Y_W-1:0]       y;
  logic signed [ACC_W-1:0]     acc;
  logic signed [Z_W-1:0]       z1;
  logic signed [Z_W-1:0]       z2;
  logic                        y_hit;
  logic                        z_hit;
  logic signed [PROD_W-1:0]    prod;

  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    mul_p;
  logic                        prod_en;
  logic                        finish;
  logic                        out_free;

  logic signed [YS_W-1:0]      y_sum;
  logic signed [YS_W-1:0]      y_sh;
  logic signed [Y_W-1:0]       y_sat;
  logic                        y_ovf;
  logic signed [ACC_W-1:0]     p37;
  logic signed [ACC_W-1:0]     z_in;
  logic signed [Z_W-1:0]       z_sat;
  logic                        z_ovf;
  logic signed [PROD_W-1:0]    val;
  logic signed [OUT_TDATA_W-1:0] res;
  logic                        o_hit;
  flags_t                      flags;

  assign out_free = !m_tvalid || m_tready;
  assign q_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    mul_a = MUL_A_W'(x);
    mul_b = MUL_B_W'(cfg.b1);
    prod_en = 1'b0;
    finish = 1'b0;
    case (state)
      S_IDLE: begin
        mul_a = MUL_A_W'(q_item.x);
        mul_b = cfg.filter_on ? MUL_B_W'(cfg.b0) : MUL_B_W'(cfg.gain);
        if (q_valid) begin
          prod_en = 1'b1;
          state_next = cfg.filter_on ? S_MB1 : S_ME;
        end
      end
      S_MB1: begin
        prod_en = 1'b1;
        state_next = S_MA1;
      end
      S_MA1: begin
        mul_a = MUL_A_W'(y);
        mul_b = MUL_B_W'(cfg.a1);
        prod_en = 1'b1;
        state_next = S_MB2;
      end
      S_MB2: begin
        mul_b = MUL_B_W'(cfg.b2);
        prod_en = 1'b1;
        state_next = S_MA2;
      end
      S_MA2: begin
        mul_a = MUL_A_W'(y);
        mul_b = MUL_B_W'(cfg.a2);
        prod_en = 1'b1;
        state_next = S_MG;
      end
      S_MG: begin
        mul_a = MUL_A_W'(y);
        mul_b = MUL_B_W'(cfg.gain);
        prod_en = 1'b1;
        state_next = S_ME;
      end
      S_ME: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = $signed({2'b00, env});
        if (env == ENV_FULL) begin
          finish = out_free;
          state_next = out_free ? S_IDLE : S_ME;
        end else begin
          prod_en = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        finish = out_free;
        state_next = out_free ? S_IDLE : S_FIN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    y_sum = YS_W'($signed(prod[2*COEF_W-1:0])) + YS_W'(z1);
    y_sh = y_sum >>> 14;
    y_ovf = 1'b1;
    if (y_sh > YS_W'(Y_MAX)) begin
      y_sat = Y_MAX;
    end else if (y_sh < YS_W'(Y_MIN)) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = y_sh[Y_W-1:0];
      y_ovf = 1'b0;
    end

    p37 = prod[ACC_W-1:0];
    z_in = (state == S_MA2) ? acc : acc - p37;
    z_ovf = 1'b1;
    if (z_in > ACC_W'(Z_MAX)) begin
      z_sat = Z_MAX;
    end else if (z_in < ACC_W'(Z_MIN)) begin
      z_sat = Z_MIN;
    end else begin
      z_sat = z_in[Z_W-1:0];
      z_ovf = 1'b0;
    end

    val = (state == S_FIN) ? (prod >>> 30) : (prod >>> 15);
    o_hit = 1'b1;
    if (val > PROD_W'(O_MAX)) begin
      res = O_MAX;
    end else if (val < PROD_W'(O_MIN)) begin
      res = O_MIN;
    end else begin
      res = val[OUT_TDATA_W-1:0];
      o_hit = 1'b0;
    end

    flags.state_clipped = z_hit;
    flags.filter_clipped = y_hit;
    flags.output_clipped = o_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      z1 <= '0;
      z2 <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_MA2) begin
        z1 <= z_sat;
      end
      if (state == S_MG) begin
        z2 <= z_sat;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod <= mul_p;
    end
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          x <= q_item.x;
          env <= q_item.env;
          y <= Y_W'(q_item.x);
          y_hit <= 1'b0;
          z_hit <= 1'b0;
        end
      end
      S_MB1: begin
        y <= y_sat;
        y_hit <= y_ovf;
      end
      S_MA1: begin
        acc <= ACC_W'($signed(prod[2*COEF_W-1:0])) + ACC_W'(z2);
      end
      S_MB2: begin
        acc <= acc - p37;
      end
      S_MA2: begin
        acc <= ACC_W'($signed(prod[2*COEF_W-1:0]));
        z_hit <= z_hit | z_ovf;
      end
      S_MG: begin
        z_hit <= z_hit | z_ovf;
      end
      default: begin
      end
    endcase
    if (finish) begin
      m_tdata <= res;
      m_tuser <= flags;
    end
  end

  a_bypass_flags: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && q_valid && !cfg.filter_on) |=> (state == S_ME && !y_hit && !z_hit))
    else $error("bypassed word took the filter path or kept clip flags");

  a_state_flag: assert property (@(posedge clk) disable iff (rst)
    (state == S_MG && z_ovf) |=> z_hit)
    else $error("state clip not recorded");

endmodule

>>> hw/rtl/voice_interp_biquad_gain_path.sv
// Channel   Dir  Ready/valid          Fields (lowest bit first)
// s_*       in   s_tvalid/s_tready    tdata: sample_near, sample_next, phase_fraction,
//                                     envelope, zero pad to 64 bits
// m_*       out  m_tvalid/m_tready    tdata: contribution; tuser: output_clipped,
//                                     filter_clipped, state_clipped
// cfg_*     in   cfg_we               cfg_index selects the register, cfg_data the value
//
// The front interpolates each word and passes it through a two-word queue. The back uses
// one shared multiplier, takes a word only in idle, and forms the b0, b1, a1, b2, a2, gain
// and envelope products; bypass forms gain and envelope only; full-scale skips envelope.
// Reset clears the registers, both delay words, the queue and the output valid flag.
// A stalled output holds the back in its last step while the front keeps filling the queue.
module voice_interp_biquad_gain_path (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [vibg_pkg::IN_TDATA_W-1:0]       s_tdata,   // near, next, fraction, envelope
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [vibg_pkg::OUT_TDATA_W-1:0]      m_tdata,   // contribution
  output logic [vibg_pkg::OUT_TUSER_W-1:0]      m_tuser,   // output, filter, state clipped
  input  logic                                  cfg_we,
  input  logic [vibg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [vibg_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import vibg_pkg::*;

  cfg_t  cfg;
  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  b_valid;
  logic  b_ready;
  item_t b_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_B0:   cfg.b0 <= cfg_data;
        REG_B1:   cfg.b1 <= cfg_data;
        REG_B2:   cfg.b2 <= cfg_data;
        REG_A1:   cfg.a1 <= cfg_data;
        REG_A2:   cfg.a2 <= cfg_data;
        REG_FILT: cfg.filter_on <= cfg_data[0];
        REG_GAIN: cfg.gain <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  vibg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item)
  );

  vibg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  vibg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_item   (b_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
